### rtl/sfd_pkg.sv
package sfd_pkg;

  // default sizes
  localparam int LINE_DEPTH_DEF  = 65536;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int IO_BITS         = 24;

  // configuration port
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WET      = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRY      = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_GAIN = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE     = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPREAD_L = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPREAD_R = 4'd7;

  // stereo modes
  localparam logic [2:0] MODE_PLAIN  = 3'd0;
  localparam logic [2:0] MODE_SPREAD = 3'd1;
  localparam logic [2:0] MODE_PP_IND = 3'd2;
  localparam logic [2:0] MODE_PP_SUM = 3'd3;
  localparam logic [2:0] MODE_PP_LR  = 3'd4;

  // register reset values
  localparam logic [23:0] DELAY_RST    = 24'd256;
  localparam logic [15:0] FEEDBACK_RST = 16'd0;
  localparam logic [15:0] WET_RST      = 16'd16384;
  localparam logic [15:0] DRY_RST      = 16'd16384;
  localparam logic [15:0] OUT_GAIN_RST = 16'd32768;
  localparam logic [6:0]  SPREAD_L_RST = 7'd0;
  localparam logic [6:0]  SPREAD_R_RST = 7'd100;

  localparam logic [15:0] GAIN_UNITY = 16'd32768;
  localparam logic [6:0]  SPREAD_MAX = 7'd100;
  localparam logic [7:0]  SPREAD_SUM = 8'd200;

  typedef struct packed {
    logic signed [IO_BITS-1:0] left_in;
    logic signed [IO_BITS-1:0] right_in;
  } in_frame_t;

  typedef struct packed {
    logic signed [IO_BITS-1:0] left_out;
    logic signed [IO_BITS-1:0] right_out;
  } out_frame_t;

  // interpolation weights for the two taps
  typedef struct packed {
    logic [8:0] wa;
    logic [7:0] wb;
  } tap_t;

  // pan for a spread sum s: rounded s*32768/200
  typedef logic [15:0] pan_tab_t [0:200];

  function automatic pan_tab_t pan_build();
    pan_tab_t t;
    for (int i = 0; i <= 200; i++) begin
      t[i] = 16'((i * 32768 + 100) / 200);
    end
    return t;
  endfunction

  localparam pan_tab_t PAN_TAB = pan_build();

endpackage

### rtl/sfd_ram.sv
module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sfd_tap.sv
module sfd_tap import sfd_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic [23:0]                   delay_q8,
  input  logic [$clog2(LINE_DEPTH)-1:0] wp,
  output logic [$clog2(LINE_DEPTH)-1:0] pa,
  output logic [$clog2(LINE_DEPTH)-1:0] pb,
  output tap_t                          tap
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int XW = (AW + 8 > 24) ? AW + 8 : 24;
  localparam logic [XW-1:0] DMIN = XW'(256);
  localparam logic [XW-1:0] DMAX = XW'((LINE_DEPTH - 1) * 256);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(LINE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);

  logic [XW-1:0] d;
  logic [XW-1:0] dc;
  logic [AW-1:0] a;
  logic [AW:0]   diff;

  // clamp the delay to one sample .. line length minus one sample
  always_comb begin
    d = XW'(delay_q8);
    if (d < DMIN) begin
      dc = DMIN;
    end else if (d > DMAX) begin
      dc = DMAX;
    end else begin
      dc = d;
    end
  end

  // whole taps back (ceil) and weights
  assign a      = dc[AW+7:8] + {{(AW-1){1'b0}}, |dc[7:0]};
  assign tap.wb = 8'(9'd256 - {1'b0, dc[7:0]});
  assign tap.wa = 9'd256 - {1'b0, tap.wb};

  // circular positions
  assign diff = {1'b0, wp} - {1'b0, a};
  assign pa   = diff[AW] ? AW'(diff + DEPTH_X) : diff[AW-1:0];
  assign pb   = (pa == LAST) ? '0 : pa + AW'(1);

endmodule

### rtl/stereo_pingpong_fractional_delay_unit.sv
// Stereo feedback delay with a fractional read position and ping-pong routing.
// Each request carries one stereo frame; one result frame comes back per
// request once both channels are done and the output register is free, and
// the next frame can be taken as that result is shown; none is taken while
// one is in work. With one shared 44x18 multiplier and the single read port
// of each delay line, per channel two tap reads, seven multiplies and one
// write-back run in sequence, left channel first. A finished frame waits in
// the output register while the next frame is already being processed. The
// delay lines are not swept after reset: a fill count over the write position
// makes entries never written read as zero, so the block takes requests
// right after reset. Configuration is written any time the block is idle;
// indexes beyond the last register are ignored.
module stereo_pingpong_fractional_delay_unit import sfd_pkg::*; #(
  parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_frame_t                in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_frame_t               out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int SB  = SAMPLE_BITS;
  localparam int XB  = (SB > IO_BITS) ? SB : IO_BITS;
  localparam int AMW = XB + 20;
  localparam int PW  = AMW + 18;
  localparam logic signed [PW-1:0] SMAX = $signed((PW'(1) << (SB - 1)) - PW'(1));
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);
  localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_MA   = 4'd3;
  localparam logic [3:0] S_MB   = 4'd4;
  localparam logic [3:0] S_DEL  = 4'd5;
  localparam logic [3:0] S_MFB  = 4'd6;
  localparam logic [3:0] S_MWET = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_MDRY = 4'd9;
  localparam logic [3:0] S_MIX  = 4'd10;
  localparam logic [3:0] S_MOG  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;
  localparam logic [3:0] S_HOLD = 4'd13;

  function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] p,
                                                  input int unsigned s);
    logic signed [PW-1:0] h;
    h = $signed(PW'(1) << (s - 1));
    return (p + h) >>> s;
  endfunction

  function automatic logic signed [PW-1:0] sat_s(input logic signed [PW-1:0] v);
    if (v > SMAX) begin
      return SMAX;
    end else if (v < SMIN) begin
      return SMIN;
    end
    return v;
  endfunction

  // configuration registers
  logic [23:0] delay_r;
  logic [15:0] fb_r, wet_r, dry_r, og_r;
  logic [2:0]  mode_r;
  logic [6:0]  sl_r, sr_r;

  // sequencer and datapath registers
  logic [3:0]            state_r, state_nxt;
  logic                  ch_r;
  logic                  pong_r;
  logic [AW-1:0]         wp_r;
  logic                  full_r;
  logic signed [IO_BITS-1:0] x_r [2];
  logic signed [IO_BITS-1:0] pin_r [2];
  logic [15:0]           pan_r [2];
  logic signed [SB-1:0]  xa_r, xb_r, del_r, back_r;
  logic                  rvalid_r;
  logic signed [PW-1:0]  prod_r, acc_r;
  logic signed [AMW-1:0] mix_r;
  logic [IO_BITS-1:0]    yl_r, yr_r;
  logic                  out_valid_r;
  out_frame_t            out_data_r;

  // combinational signals
  logic [15:0]           fb_c, wet_c, dry_c;
  logic [6:0]            sl_c, sr_c;
  logic [7:0]            ssum;
  logic                  pong, sum_mode;
  logic [AW-1:0]         pa, pb, raddr;
  tap_t                  tap;
  logic                  rd_ok;
  logic signed [SB-1:0]  rdata_l, rdata_r, rdata_sel, rmask;
  logic signed [AMW-1:0] mul_a;
  logic signed [17:0]    mul_b;
  logic signed [PW-1:0]  pin_w, del_w, back_w, y_w, pp_w;
  logic signed [IO_BITS:0] lr_sum;
  logic                  we_l, we_r;
  logic                  dst;
  logic                  accept, load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
      fb_r    <= FEEDBACK_RST;
      wet_r   <= WET_RST;
      dry_r   <= DRY_RST;
      og_r    <= OUT_GAIN_RST;
      mode_r  <= MODE_PLAIN;
      sl_r    <= SPREAD_L_RST;
      sr_r    <= SPREAD_R_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELAY:    delay_r <= cfg_data[23:0];
        REG_FEEDBACK: fb_r    <= cfg_data[15:0];
        REG_WET:      wet_r   <= cfg_data[15:0];
        REG_DRY:      dry_r   <= cfg_data[15:0];
        REG_OUT_GAIN: og_r    <= cfg_data[15:0];
        REG_MODE:     mode_r  <= cfg_data[2:0];
        REG_SPREAD_L: sl_r    <= cfg_data[6:0];
        REG_SPREAD_R: sr_r    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // gain and spread clamps, mode decode
  assign fb_c     = (fb_r > GAIN_UNITY) ? GAIN_UNITY : fb_r;
  assign wet_c    = (wet_r > GAIN_UNITY) ? GAIN_UNITY : wet_r;
  assign dry_c    = (dry_r > GAIN_UNITY) ? GAIN_UNITY : dry_r;
  assign sl_c     = (sl_r > SPREAD_MAX) ? SPREAD_MAX : sl_r;
  assign sr_c     = (sr_r > SPREAD_MAX) ? SPREAD_MAX : sr_r;
  assign ssum     = {1'b0, sl_c} + {1'b0, sr_c};
  assign pong     = (mode_r == MODE_PP_IND) || (mode_r == MODE_PP_SUM) ||
                    (mode_r == MODE_PP_LR);
  assign sum_mode = (mode_r == MODE_PP_SUM) || (mode_r == MODE_PP_LR);
  assign lr_sum   = $signed({in_data.left_in[IO_BITS-1], in_data.left_in}) +
                    $signed({in_data.right_in[IO_BITS-1], in_data.right_in}) +
                    $signed((IO_BITS + 1)'(1));

  // tap positions and weights
  sfd_tap #(.LINE_DEPTH(LINE_DEPTH)) u_tap (
    .delay_q8 (delay_r),
    .wp       (wp_r),
    .pa       (pa),
    .pb       (pb),
    .tap      (tap)
  );

  // delay lines
  assign raddr = (state_r == S_RDA) ? pa : pb;
  assign dst   = pong_r ? ~ch_r : ch_r;
  assign we_l  = (state_r == S_WR) && !dst;
  assign we_r  = (state_r == S_WR) && dst;

  sfd_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_line_l (
    .clk   (clk),
    .we    (we_l),
    .waddr (wp_r),
    .wdata (back_r),
    .raddr (raddr),
    .rdata (rdata_l)
  );

  sfd_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_line_r (
    .clk   (clk),
    .we    (we_r),
    .waddr (wp_r),
    .wdata (back_r),
    .raddr (raddr),
    .rdata (rdata_r)
  );

  // fill count: written entries, plus this frame's left write in ping-pong
  assign rd_ok     = full_r || (raddr < wp_r) || (ch_r && pong_r && (raddr == wp_r));
  assign rdata_sel = ch_r ? rdata_r : rdata_l;
  assign rmask     = rvalid_r ? rdata_sel : '0;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MA: begin
        mul_a = AMW'(xa_r);
        mul_b = $signed({9'd0, tap.wa});
      end
      S_MB: begin
        mul_a = AMW'(xb_r);
        mul_b = $signed({10'd0, tap.wb});
      end
      S_MFB: begin
        mul_a = AMW'(del_r);
        mul_b = $signed({2'd0, fb_c});
      end
      S_MWET: begin
        mul_a = AMW'(del_r);
        mul_b = $signed({2'd0, wet_c});
      end
      S_WR: begin
        mul_a = AMW'(prod_r);
        mul_b = $signed({2'd0, pan_r[ch_r]});
      end
      S_MDRY: begin
        mul_a = AMW'(x_r[ch_r]);
        mul_b = $signed({2'd0, dry_c});
      end
      S_MOG: begin
        mul_a = mix_r;
        mul_b = $signed({2'd0, og_r});
      end
      default: ;
    endcase
  end

  // rounding and saturation steps
  always_comb begin
    pin_w  = PW'(pin_r[ch_r]);
    pp_w   = acc_r + prod_r;
    del_w  = rnd_sh(pp_w, 8);
    back_w = sat_s(pin_w + rnd_sh(prod_r, 15));
    y_w    = sat_s(rnd_sh(prod_r, 30));
  end

  assign load_out = (state_r == S_HOLD) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_RDA;
      S_RDA:   state_nxt = S_RDB;
      S_RDB:   state_nxt = S_MA;
      S_MA:    state_nxt = S_MB;
      S_MB:    state_nxt = S_DEL;
      S_DEL:   state_nxt = S_MFB;
      S_MFB:   state_nxt = S_MWET;
      S_MWET:  state_nxt = S_WR;
      S_WR:    state_nxt = S_MDRY;
      S_MDRY:  state_nxt = S_MIX;
      S_MIX:   state_nxt = S_MOG;
      S_MOG:   state_nxt = S_OUT;
      S_OUT:   state_nxt = ch_r ? S_HOLD : S_RDA;
      S_HOLD:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      wp_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        ch_r <= 1'b0;
      end else if (state_r == S_OUT) begin
        ch_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        wp_r        <= (wp_r == LAST) ? '0 : wp_r + AW'(1);
        if (wp_r == LAST) begin
          full_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r   <= mul_a * mul_b;
    rvalid_r <= rd_ok;
    if (accept) begin
      x_r[0] <= in_data.left_in;
      x_r[1] <= in_data.right_in;
      pong_r <= pong;
      if (sum_mode) begin
        pin_r[0] <= '0;
        pin_r[1] <= IO_BITS'(lr_sum >>> 1);
      end else begin
        pin_r[0] <= in_data.left_in;
        pin_r[1] <= in_data.right_in;
      end
      if (mode_r == MODE_SPREAD) begin
        pan_r[0] <= PAN_TAB[8'(SPREAD_SUM - ssum)];
        pan_r[1] <= PAN_TAB[ssum];
      end else begin
        pan_r[0] <= GAIN_UNITY;
        pan_r[1] <= GAIN_UNITY;
      end
    end
    case (state_r)
      S_RDB:  xa_r   <= rmask;
      S_MA:   xb_r   <= rmask;
      S_MB:   acc_r  <= prod_r;
      S_DEL:  del_r  <= SB'(del_w);
      S_MWET: back_r <= SB'(back_w);
      S_MDRY: acc_r  <= rnd_sh(prod_r, 15);
      S_MIX:  mix_r  <= AMW'(prod_r + acc_r);
      S_OUT: begin
        if (ch_r) begin
          yr_r <= y_w[IO_BITS-1:0];
        end else begin
          yl_r <= y_w[IO_BITS-1:0];
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_data_r.left_out  <= yl_r;
      out_data_r.right_out <= yr_r;
    end
  end

`ifndef SYNTHESIS
  a_one_line_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_l && we_r))
    else $error("both delay lines written in one cycle");

  a_start_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RDA) && !ch_r)
    else $error("accepted frame did not start with the left tap read");

  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_HOLD))
    else $error("result shown without a finished frame");

  a_wp_moves_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r != $past(wp_r)) |-> $past(load_out))
    else $error("write position moved outside frame completion");
`endif

endmodule
